// ===== rtl/cmfseg_pkg.sv =====
// ---------------------------------------------------------------------------
// cmfseg_pkg
// Types and constants shared by the CAN multi-frame segmenter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cmfseg_pkg;

   localparam int SLOT_COUNT   = 7;
   localparam int BYTE_W       = 8;
   localparam int ID_W         = 11;
   localparam int REQ_TDATA_W  = 16;
   localparam int FRAME_BITS   = ID_W + BYTE_W + SLOT_COUNT * BYTE_W;
   localparam int RSP_TDATA_W  = ((FRAME_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - FRAME_BITS;

   localparam logic [BYTE_W-1:0] CTRL_START = 8'h80;
   localparam logic [BYTE_W-1:0] CTRL_END   = 8'hFF;
   localparam logic [BYTE_W-1:0] LEN_MASK   = 8'h7F;

   // per-request control handed to every slot cell
   typedef struct packed {
      logic take;   // a byte of a live message is accepted
      logic flush;  // this byte closes the frame
   } cell_ctrl_type;

   typedef struct packed {
      logic [SLOT_COUNT-1:0][BYTE_W-1:0] payload;
      logic [BYTE_W-1:0]                 control;
      logic [ID_W-1:0]                   id;
   } frame_type;

endpackage

`default_nettype wire

// ===== rtl/cmfseg_cell.sv =====
// ---------------------------------------------------------------------------
// cmfseg_cell
// One payload slot of the frame buffer; a write token passes along the row.
// ---------------------------------------------------------------------------
`default_nettype none

module cmfseg_cell
   import cmfseg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic                is_head,
   input  wire logic                token_prev,
   input  wire logic [BYTE_W-1:0]   data_byte,
   output logic                     token_out,
   output logic [BYTE_W-1:0]        slot_out
);

   logic              token_ff;
   logic              token_in;
   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              take_here;

   assign take_here = ctrl.take & token_ff;

   always_comb begin
      token_in = token_ff;
      valid_in = valid_ff;
      if (ctrl.take) begin
         if (ctrl.flush) begin
            token_in = is_head;
            valid_in = 1'b0;
         end else begin
            token_in = token_prev;
            valid_in = valid_ff | token_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= is_head;
         valid_ff <= 1'b0;
      end else begin
         token_ff <= token_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_here) begin
         byte_ff <= data_byte;
      end
   end

   // byte arriving now goes straight through, empty slots read as zero pad
   assign slot_out  = take_here ? data_byte : (valid_ff ? byte_ff : '0);
   assign token_out = token_ff;

endmodule

`default_nettype wire

// ===== rtl/cmfseg_out_buf.sv =====
// ---------------------------------------------------------------------------
// cmfseg_out_buf
// Output register with one skid entry for finished frames.
// ---------------------------------------------------------------------------
`default_nettype none

module cmfseg_out_buf
   import cmfseg_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire frame_type push_frame,
   output logic           space,
   output logic           out_valid,
   input  wire logic      out_ready,
   output frame_type      out_frame
);

   logic      head_valid_ff;
   logic      head_valid_in;
   logic      skid_valid_ff;
   logic      skid_valid_in;
   frame_type head_ff;
   frame_type head_in;
   frame_type skid_ff;
   frame_type skid_in;
   logic      head_free;

   assign head_free = ~head_valid_ff | out_ready;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (head_free) begin
            head_valid_in = 1'b1;
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (head_free) begin
            head_valid_in = 1'b1;
            head_in       = push_frame;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_frame;
         end
      end else if (head_free) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign space     = ~skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_frame = head_ff;

endmodule

`default_nettype wire

// ===== rtl/can_multiframe_segmenter_top.sv =====
// ---------------------------------------------------------------------------
// can_multiframe_segmenter_top
// Packs a byte stream into 8-byte CAN frames with a control byte in front.
// ---------------------------------------------------------------------------
// One message byte is taken per cycle; a request is never held off unless two
// finished frames are waiting on the rsp side (output register plus one skid
// entry). The frame that a request's last byte completes goes into the output
// register and onto rsp, or into the skid entry while an earlier frame still
// waits in the output register. Payload slots sit in a row of seven cells
// through which a write token walks, one cell per byte; the token reaching the
// last cell or the byte counter meeting the latched length closes a frame.
// Messages of seven bytes or fewer give one end frame (control 0xff); longer
// ones give a start frame (0x80 | length[6:0]), numbered middle frames and an
// end frame padded with zeros. A first byte whose length is zero is dropped.
// The identifier on each frame is the csr value when the frame is completed.
`default_nettype none

module can_multiframe_segmenter_top
   import cmfseg_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = 255
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [ID_W-1:0]        csr_wr_data,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // data_byte [7:0], message_length [15:8]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // out_id [10:0], control_byte [18:11], payload_0 .. payload_6 [74:19],
   // zero [79:75]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_MESSAGE_BYTES);

   logic [ID_W-1:0]   frame_id_ff;
   logic [BYTE_W-1:0] latched_length_ff;
   logic [BYTE_W-1:0] bytes_taken_ff;
   logic [BYTE_W-1:0] bytes_taken_in;
   logic [BYTE_W-1:0] middle_sequence_ff;
   logic [BYTE_W-1:0] middle_sequence_in;

   logic [BYTE_W-1:0] data_byte;
   logic [BYTE_W-1:0] message_length;
   logic              req_fire;
   logic              first_byte;
   logic              discard;
   logic [BYTE_W-1:0] len_eff;
   logic [BYTE_W-1:0] taken_next;
   logic              is_end;
   logic              is_full;
   logic              is_start;
   logic              emit;
   cell_ctrl_type     cell_ctrl;
   frame_type         new_frame;
   frame_type         rsp_frame;
   logic              buf_space;

   logic [SLOT_COUNT-1:0]             token;
   logic [SLOT_COUNT-1:0]             token_prev;
   logic [SLOT_COUNT-1:0][BYTE_W-1:0] slot;

   assign data_byte      = req_tdata[BYTE_W-1:0];
   assign message_length = req_tdata[2*BYTE_W-1:BYTE_W];

   assign req_tready = buf_space;
   assign req_fire   = req_tvalid & req_tready;

   assign first_byte = (bytes_taken_ff == '0);
   assign discard    = first_byte & (message_length == '0);
   assign len_eff    = first_byte ? ((message_length > MAX_LEN) ? MAX_LEN : message_length)
                                  : latched_length_ff;
   assign taken_next = bytes_taken_ff + 1'b1;
   assign is_end     = (taken_next >= len_eff);
   assign is_full    = token[SLOT_COUNT-1];
   assign is_start   = (taken_next == BYTE_W'(SLOT_COUNT));
   assign emit       = cell_ctrl.take & (is_end | is_full);

   assign cell_ctrl.take  = req_fire & ~discard;
   assign cell_ctrl.flush = is_end | is_full;

   assign token_prev = {token[SLOT_COUNT-2:0], 1'b0};

   for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
      cmfseg_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .is_head    (k == 0),
         .token_prev (token_prev[k]),
         .data_byte  (data_byte),
         .token_out  (token[k]),
         .slot_out   (slot[k])
      );
   end

   always_comb begin
      bytes_taken_in     = bytes_taken_ff;
      middle_sequence_in = middle_sequence_ff;
      if (cell_ctrl.take) begin
         if (is_end) begin
            bytes_taken_in     = '0;
            middle_sequence_in = '0;
         end else begin
            bytes_taken_in = taken_next;
            if (first_byte) begin
               middle_sequence_in = '0;
            end else if (is_full & ~is_start) begin
               middle_sequence_in = middle_sequence_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      new_frame.id      = frame_id_ff;
      new_frame.payload = slot;
      if (is_end) begin
         new_frame.control = CTRL_END;
      end else if (is_start) begin
         new_frame.control = CTRL_START | (len_eff & LEN_MASK);
      end else begin
         new_frame.control = middle_sequence_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_id_ff        <= '0;
         latched_length_ff  <= '0;
         bytes_taken_ff     <= '0;
         middle_sequence_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            frame_id_ff <= csr_wr_data;
         end
         if (cell_ctrl.take) begin
            latched_length_ff <= len_eff;
         end
         bytes_taken_ff     <= bytes_taken_in;
         middle_sequence_ff <= middle_sequence_in;
      end
   end

   cmfseg_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (emit),
      .push_frame (new_frame),
      .space      (buf_space),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_frame  (rsp_frame)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_frame.payload, rsp_frame.control, rsp_frame.id};

endmodule

`default_nettype wire

// ===== rtl/cmfseg_checker.sv =====
// ---------------------------------------------------------------------------
// cmfseg_checker
// Port-level checks on the segmenter, bound onto the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module cmfseg_checker
   import cmfseg_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // nothing is shown on rsp straight after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // a new frame only appears after a request has been taken
   a_frame_needs_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("frame appeared without a request");

   // back-pressure on req only while frames are queued on rsp
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with rsp empty");

   // stalled frame holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp frame changed while stalled");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:FRAME_BITS] == '0)
      else $error("rsp pad bits not zero");

endmodule

bind can_multiframe_segmenter_top cmfseg_checker u_cmfseg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/can_multiframe_segmenter_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// can_multiframe_segmenter_top_tb
// Self-checking bench for the CAN multi-frame segmenter. A short table of
// requests covers the dropped zero-length case, a one-byte message, a full
// seven-byte message and the first start frame. Random messages of mixed
// length follow under several idling patterns and csr identifiers. Every
// frame is checked field by field against its table entry or a local model.
// ---------------------------------------------------------------------------

module can_multiframe_segmenter_top_tb;
   import cmfseg_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_BYTES  = 60;
   localparam int PHASE_COUNT  = 5;

   typedef enum {QUIET, SEND_IDLE, RECV_STALL, BOTH_IDLE} idle_mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] len;
      logic              typed;
      logic              typed_hit;
      frame_type         typed_frame;
   } step_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [ID_W-1:0]        csr_wr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic rsp_hold = 1'b0;
   logic hold_go = 1'b0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;

   // model state
   logic [ID_W-1:0]   can_id = '0;
   logic [BYTE_W-1:0] msg_len = '0;
   logic [BYTE_W-1:0] msg_taken = '0;
   logic [BYTE_W-1:0] mid_seq = '0;
   int                slot_fill = 0;
   logic [BYTE_W-1:0] slot_bytes [0:SLOT_COUNT-1];

   frame_type frames_due [$];
   step_row_type directed_rows [$];

   int errors = 0;
   int frames_seen = 0;
   int msg_bytes = 0;
   int dropped_reqs = 0;
   int held_cycles = 0;
   int cycle_count = 0;

   can_multiframe_segmenter_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frames outstanding", cycle_count,
                  frames_due.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   // one byte through the segmenter model; hit is set when a frame closes
   task automatic segment_byte(input logic [BYTE_W-1:0] data, input logic [BYTE_W-1:0] len,
                               output logic hit, output frame_type frame);
      logic close;
      int   k;
      hit   = 1'b0;
      close = 1'b0;
      frame = '0;
      if (msg_taken == 0) begin
         if (len == 0)
            return;
         msg_len   = len;
         mid_seq   = '0;
         slot_fill = 0;
      end
      slot_bytes[slot_fill] = data;
      slot_fill++;
      msg_taken++;
      if (msg_taken >= msg_len) begin
         hit           = 1'b1;
         close         = 1'b1;
         frame.control = CTRL_END;
      end else if (slot_fill == SLOT_COUNT) begin
         hit = 1'b1;
         if (msg_taken == SLOT_COUNT) begin
            frame.control = CTRL_START | (msg_len & LEN_MASK);
         end else begin
            frame.control = mid_seq;
            mid_seq++;
         end
      end
      if (hit) begin
         frame.id = can_id;
         for (k = 0; k < SLOT_COUNT; k++)
            frame.payload[k] = (k < slot_fill) ? slot_bytes[k] : '0;
         slot_fill = 0;
         if (close) begin
            msg_taken = '0;
            mid_seq   = '0;
         end
      end
   endtask

   task automatic check_frame(input logic [RSP_TDATA_W-1:0] word);
      frame_type got;
      frame_type want;
      int        k;
      got = word[FRAME_BITS-1:0];
      frames_seen++;
      if (frames_due.size() == 0) begin
         report($sformatf("frame %0d arrived with nothing pending: %h", frames_seen, word));
         return;
      end
      want = frames_due.pop_front();
      if (got.id !== want.id)
         report($sformatf("frame %0d out_id got %h want %h", frames_seen, got.id, want.id));
      if (got.control !== want.control)
         report($sformatf("frame %0d control_byte got %h want %h", frames_seen,
                          got.control, want.control));
      for (k = 0; k < SLOT_COUNT; k++)
         if (got.payload[k] !== want.payload[k])
            report($sformatf("frame %0d payload_%0d got %h want %h", frames_seen, k,
                             got.payload[k], want.payload[k]));
      if (word[RSP_TDATA_W-1:FRAME_BITS] !== '0)
         report($sformatf("frame %0d pad bits not zero: %h", frames_seen,
                          word[RSP_TDATA_W-1:FRAME_BITS]));
   endtask

   // receive side: check, count input stalls, pick next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_frame(rsp_tdata);
         if (req_tvalid && !req_tready)
            held_cycles++;
         rsp_tready <= !rsp_hold && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // long hold-off of the result side, timed here and not by the sender
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic step_row_type end_frame_at_reset(
         input logic [BYTE_W-1:0] p0, p1, p2, p3, p4, p5, p6,
         input logic [BYTE_W-1:0] data, len);
      step_row_type row;
      row                     = '0;
      row.data                = data;
      row.len                 = len;
      row.typed               = 1'b1;
      row.typed_hit           = 1'b1;
      row.typed_frame.control = CTRL_END;
      row.typed_frame.payload = {p6, p5, p4, p3, p2, p1, p0};
      return row;
   endfunction

   task automatic add_row(input logic [BYTE_W-1:0] data, len, input logic typed);
      step_row_type row;
      row       = '0;
      row.data  = data;
      row.len   = len;
      row.typed = typed;
      directed_rows.push_back(row);
   endtask

   task automatic send_request(input step_row_type row);
      logic      hit;
      frame_type frame;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row.len, row.data};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      segment_byte(row.data, row.len, hit, frame);
      if (row.typed) begin
         hit   = row.typed_hit;
         frame = row.typed_frame;
      end
      if (hit)
         frames_due.push_back(frame);
   endtask

   task automatic send_message(input int len);
      step_row_type row;
      int           i;
      for (i = 0; i < len; i++) begin
         row      = '0;
         row.data = 8'($urandom_range(0, 255));
         // length only counts on the first byte
         row.len  = (i == 0) ? 8'(len) : 8'($urandom_range(0, 255));
         send_request(row);
      end
      msg_bytes += len;
   endtask

   task automatic wait_drain;
      req_tvalid <= 1'b0;
      while (frames_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_id(input logic [ID_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      can_id = value;
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         QUIET: begin
            send_idle_pct = 0;
            recv_stall_pct <= 0;
         end
         SEND_IDLE: begin
            send_idle_pct = 75;
            recv_stall_pct <= 0;
         end
         RECV_STALL: begin
            send_idle_pct = 0;
            recv_stall_pct <= 75;
         end
         default: begin
            send_idle_pct = 14;
            recv_stall_pct <= 14;
         end
      endcase
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6)
         return $urandom_range(1, 15);
      else if (r < 9)
         return $urandom_range(16, 60);
      return $urandom_range(61, 160);
   endfunction

   initial begin
      step_row_type  row;
      idle_mode_type modes [PHASE_COUNT];
      int            p;
      int            phase_bytes;

      modes = '{QUIET, SEND_IDLE, RECV_STALL, BOTH_IDLE, QUIET};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // identifier still at its reset value of zero
      add_row(8'hA5, 8'h00, 1'b1);
      directed_rows.push_back(end_frame_at_reset(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                                                 8'h00, 8'h00, 8'hFF, 8'h01));
      add_row(8'h5A, 8'h00, 1'b1);
      add_row(8'h00, 8'h07, 1'b0);
      add_row(8'h01, 8'h00, 1'b0);
      add_row(8'h02, 8'hFF, 1'b0);
      add_row(8'h04, 8'h80, 1'b0);
      add_row(8'h08, 8'h01, 1'b0);
      add_row(8'h10, 8'h7F, 1'b0);
      directed_rows.push_back(end_frame_at_reset(8'h00, 8'h01, 8'h02, 8'h04, 8'h08,
                                                 8'h10, 8'h20, 8'h20, 8'h7E));
      add_row(8'h40, 8'h08, 1'b0);
      add_row(8'h80, 8'h55, 1'b0);
      add_row(8'hFE, 8'hAA, 1'b0);
      add_row(8'hFD, 8'h00, 1'b0);
      add_row(8'hFB, 8'h33, 1'b0);
      add_row(8'hF7, 8'hCC, 1'b0);
      add_row(8'hEF, 8'h0F, 1'b0);
      add_row(8'hDF, 8'hF0, 1'b0);

      set_idle(QUIET);
      foreach (directed_rows[i])
         send_request(directed_rows[i]);
      dropped_reqs += 2;
      msg_bytes += 16;
      wait_drain();

      for (p = 0; p < PHASE_COUNT; p++) begin
         set_idle(modes[p]);
         case (p)
            0: write_frame_id(11'h7FF);
            1: write_frame_id(11'h000);
            2: write_frame_id(ID_W'($urandom_range(1, 2046)));
            3: write_frame_id(11'h555);
            default: write_frame_id(11'h2AA);
         endcase
         phase_bytes = 0;
         if (p == PHASE_COUNT - 1) begin
            // longest message while the result side is blocked
            hold_go <= 1'b1;
            send_message(255);
            phase_bytes = 255;
         end
         while (phase_bytes < PHASE_BYTES) begin
            if ($urandom_range(0, 7) == 0) begin
               row      = '0;
               row.data = 8'($urandom_range(0, 255));
               send_request(row);
               dropped_reqs++;
            end
            row.len = 8'(pick_length());
            send_message(int'(row.len));
            phase_bytes += int'(row.len);
         end
         wait_drain();
      end

      if (frames_due.size() != 0)
         report($sformatf("%0d frames never arrived", frames_due.size()));

      $display("sent %0d message bytes and %0d zero-length requests, checked %0d frames",
               msg_bytes, dropped_reqs, frames_seen);
      $display("five identifiers, four idling patterns, input held off for %0d cycles",
               held_cycles);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== can_multiframe_segmenter_top.f =====
rtl/cmfseg_pkg.sv
rtl/cmfseg_cell.sv
rtl/cmfseg_out_buf.sv
rtl/can_multiframe_segmenter_top.sv
rtl/cmfseg_checker.sv
tb/can_multiframe_segmenter_top_tb.sv
